// File: rtl/dptc_pkg.sv
// ----------------------------------------------------------------------------
// dptc_pkg
// Shared types, widths and register codes of the depth point to color pixel
// mapper.
// ----------------------------------------------------------------------------
package dptc_pkg;

  localparam int IMG_WIDTH_DEF  = 640;
  localparam int IMG_HEIGHT_DEF = 480;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // item fields
  localparam int PT_XY_W = 21;
  localparam int PT_Z_W  = 19;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int IDX_W   = 19;
  localparam int STAT_W  = 2;

  // datapath
  localparam int COEF_W = 20;
  localparam int XC_W   = 25;
  localparam int ZC_W   = 24;
  localparam int REM_W  = 25;
  localparam int DIV_N  = 29;
  localparam int XP_W   = DIV_N + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT0  = 3'd0,
    CFG_ROT1  = 3'd1,
    CFG_ROT2  = 3'd2,
    CFG_TRANS = 3'd3,
    CFG_INTR  = 3'd4,
    CFG_RAD   = 3'd5,
    CFG_TAN   = 3'd6
  } dptc_cfg_idx_t;

  typedef enum logic [STAT_W-1:0] {
    ST_MAPPED  = 2'd0,
    ST_NODEPTH = 2'd1,
    ST_OUTSIDE = 2'd2
  } dptc_stat_t;

  typedef struct packed {
    dptc_stat_t stat;
    logic       neg_x;
    logic       neg_y;
  } dptc_side_t;

endpackage

// File: rtl/dptc_pt_if.sv
// ----------------------------------------------------------------------------
// dptc_pt_if
// Point channel: one depth-camera point per item.
// ----------------------------------------------------------------------------
interface dptc_pt_if;
  import dptc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [PT_XY_W-1:0] point_x;
  logic signed [PT_XY_W-1:0] point_y;
  logic [PT_Z_W-1:0]         point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

// File: rtl/dptc_px_if.sv
// ----------------------------------------------------------------------------
// dptc_px_if
// Pixel channel: one color-image pixel and status per item.
// ----------------------------------------------------------------------------
interface dptc_px_if;
  import dptc_pkg::*;

  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  pixel_col;
  logic [ROW_W-1:0]  pixel_row;
  logic [IDX_W-1:0]  pixel_index;
  logic [STAT_W-1:0] status;

  modport source (output valid, pixel_col, pixel_row, pixel_index, status, input ready);
  modport sink   (input valid, pixel_col, pixel_row, pixel_index, status, output ready);
endinterface

// File: rtl/dptc_div.sv
// ----------------------------------------------------------------------------
// dptc_div
// Pipelined restoring divider pair: |x| * 2^28 / z and |y| * 2^28 / z, one
// quotient bit per stage, signs restored at the end (truncating toward zero).
// ----------------------------------------------------------------------------
module dptc_div (
  input  logic                                clk,
  input  logic                                adv,
  input  logic [dptc_pkg::REM_W-1:0]          abs_x,
  input  logic [dptc_pkg::REM_W-1:0]          abs_y,
  input  logic [dptc_pkg::ZC_W-1:0]           zc,
  input  dptc_pkg::dptc_side_t                side_i,
  output logic signed [dptc_pkg::XP_W-1:0]    xp,
  output logic signed [dptc_pkg::XP_W-1:0]    yp,
  output dptc_pkg::dptc_side_t                side_o
);
  import dptc_pkg::*;

  logic [REM_W-1:0] rx_r [DIV_N];
  logic [REM_W-1:0] ry_r [DIV_N];
  logic [DIV_N-1:0] qx_r [DIV_N];
  logic [DIV_N-1:0] qy_r [DIV_N];
  logic [ZC_W-1:0]  z_r  [DIV_N];
  dptc_side_t       sd_r [DIV_N];

  for (genvar k = 0; k < DIV_N; k++) begin : g_stg
    logic [REM_W-1:0] rx_in, ry_in, dx, dy;
    logic [DIV_N-1:0] qx_in, qy_in;
    logic [ZC_W-1:0]  z_in;
    dptc_side_t       sd_in;
    logic             gx, gy;

    if (k == 0) begin : g_first
      assign rx_in = abs_x;
      assign ry_in = abs_y;
      assign qx_in = '0;
      assign qy_in = '0;
      assign z_in  = zc;
      assign sd_in = side_i;
    end else begin : g_next
      assign rx_in = rx_r[k-1];
      assign ry_in = ry_r[k-1];
      assign qx_in = qx_r[k-1];
      assign qy_in = qy_r[k-1];
      assign z_in  = z_r[k-1];
      assign sd_in = sd_r[k-1];
    end

    // remainder stays below z, so the doubled value fits
    assign gx = rx_in >= REM_W'(z_in);
    assign gy = ry_in >= REM_W'(z_in);
    assign dx = gx ? rx_in - REM_W'(z_in) : rx_in;
    assign dy = gy ? ry_in - REM_W'(z_in) : ry_in;

    always_ff @(posedge clk) begin
      if (adv) begin
        rx_r[k] <= {dx[REM_W-2:0], 1'b0};
        ry_r[k] <= {dy[REM_W-2:0], 1'b0};
        qx_r[k] <= {qx_in[DIV_N-2:0], gx};
        qy_r[k] <= {qy_in[DIV_N-2:0], gy};
        z_r[k]  <= z_in;
        sd_r[k] <= sd_in;
      end
    end
  end

  assign xp     = sd_r[DIV_N-1].neg_x ? -$signed({1'b0, qx_r[DIV_N-1]})
                                      :  $signed({1'b0, qx_r[DIV_N-1]});
  assign yp     = sd_r[DIV_N-1].neg_y ? -$signed({1'b0, qy_r[DIV_N-1]})
                                      :  $signed({1'b0, qy_r[DIV_N-1]});
  assign side_o = sd_r[DIV_N-1];

endmodule

// File: rtl/depth_point_to_color_pixel_core.sv
// ----------------------------------------------------------------------------
// depth_point_to_color_pixel_core
// Maps a depth-camera 3D point to a color-image pixel through a rigid
// transform, pinhole projection and radial/tangential lens distortion.
// ----------------------------------------------------------------------------
// Usage:
//   in_pt  : one point per item (X, Y signed, Z unsigned, 16 fraction bits).
//   out_px : one item per point: column, row, linear index and status
//            (mapped, no depth / behind camera, outside frame).
//   cfg_*  : write-only register port; write while the block is idle.
// Throughput: one item per clock while no result waits with out_px.ready low.
// Stages: the two dividers make up 29 of the pipeline stages, one quotient
//   bit each; the transform, the range checks and the distortion, projection
//   and index steps take the rest.
// Reset: clears all stage valid bits and the configuration registers to zero;
//   the block takes items as soon as reset is released.
// Stall: when a result waits with out_px.ready low, the whole pipeline holds
//   and in_pt.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module depth_point_to_color_pixel_core #(
  parameter int IMG_WIDTH  = dptc_pkg::IMG_WIDTH_DEF,
  parameter int IMG_HEIGHT = dptc_pkg::IMG_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  dptc_pt_if.sink                             in_pt,
  dptc_px_if.source                           out_px,
  input  logic                                cfg_we,
  input  logic [dptc_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [dptc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import dptc_pkg::*;

  localparam int NS    = DIV_N + 9;
  localparam int COL_B = $clog2(IMG_WIDTH);
  localparam int ROW_B = $clog2(IMG_HEIGHT);
  localparam int IX_W  = (COL_B + ROW_B > IDX_W) ? COL_B + ROW_B : IDX_W;
  localparam logic signed [31:0] WIDTH_S  = 32'(IMG_WIDTH);
  localparam logic signed [31:0] HEIGHT_S = 32'(IMG_HEIGHT);

  // configuration registers
  logic [59:0] rot_r [3];
  logic [59:0] trans_r;
  logic [63:0] intr_r;
  logic [59:0] rad_r;
  logic [39:0] tan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= '0;
      rot_r[1] <= '0;
      rot_r[2] <= '0;
      trans_r  <= '0;
      intr_r   <= '0;
      rad_r    <= '0;
      tan_r    <= '0;
    end else if (cfg_we) begin
      case (dptc_cfg_idx_t'(cfg_idx))
        CFG_ROT0:  rot_r[0] <= cfg_wdata[59:0];
        CFG_ROT1:  rot_r[1] <= cfg_wdata[59:0];
        CFG_ROT2:  rot_r[2] <= cfg_wdata[59:0];
        CFG_TRANS: trans_r  <= cfg_wdata[59:0];
        CFG_INTR:  intr_r   <= cfg_wdata;
        CFG_RAD:   rad_r    <= cfg_wdata[59:0];
        CFG_TAN:   tan_r    <= cfg_wdata[39:0];
        default: ;
      endcase
    end
  end

  logic signed [COEF_W-1:0] rm [3][3];
  logic signed [COEF_W-1:0] tv [3];
  logic signed [COEF_W-1:0] k1, k2, k3, p1, p2;
  logic [15:0]              fx, fy, cx, cy;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int e = 0; e < 3; e++) begin
        rm[r][e] = $signed(rot_r[r][20*e +: 20]);
      end
      tv[r] = $signed(trans_r[20*r +: 20]);
    end
  end

  assign k1 = $signed(rad_r[19:0]);
  assign k2 = $signed(rad_r[39:20]);
  assign k3 = $signed(rad_r[59:40]);
  assign p1 = $signed(tan_r[19:0]);
  assign p2 = $signed(tan_r[39:20]);
  assign fx = intr_r[15:0];
  assign fy = intr_r[31:16];
  assign cx = intr_r[47:32];
  assign cy = intr_r[63:48];

  // global advance: the pipeline moves unless a result waits
  logic          adv;
  logic [NS-1:0] vld_r;

  assign adv         = !vld_r[NS-1] || out_px.ready;
  assign in_pt.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_pt.valid};
    end
  end

  // stage 0: rigid transform
  logic signed [42:0]     acc [3];
  logic signed [XC_W-1:0] s0_c_r [3];
  logic                   s0_nz_r;
  logic signed [PT_XY_W-1:0] pz_s;

  assign pz_s = $signed({2'b00, in_pt.point_z});

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 43'(rm[r][0] * in_pt.point_x) + 43'(rm[r][1] * in_pt.point_y)
             + 43'(rm[r][2] * pz_s) + $signed({{5{tv[r][COEF_W-1]}}, tv[r], 18'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        s0_c_r[r] <= $signed(acc[r][42:18]);
      end
      s0_nz_r <= in_pt.point_z != '0;
    end
  end

  // stage 1: depth and field-of-view checks, magnitudes for the dividers
  logic [REM_W-1:0] ax_c, ay_c, s1_ax_r, s1_ay_r;
  logic [ZC_W-1:0]  s1_z_r;
  dptc_side_t       side_c, s1_side_r;

  assign ax_c = s0_c_r[0][XC_W-1] ? REM_W'(-s0_c_r[0]) : REM_W'(s0_c_r[0]);
  assign ay_c = s0_c_r[1][XC_W-1] ? REM_W'(-s0_c_r[1]) : REM_W'(s0_c_r[1]);

  always_comb begin
    side_c.neg_x = s0_c_r[0][XC_W-1];
    side_c.neg_y = s0_c_r[1][XC_W-1];
    if (!s0_nz_r || s0_c_r[2] <= 0) begin
      side_c.stat = ST_NODEPTH;
    end else if ({1'b0, ax_c} >= {1'b0, s0_c_r[2][ZC_W-1:0], 1'b0} ||
                 {1'b0, ay_c} >= {1'b0, s0_c_r[2][ZC_W-1:0], 1'b0}) begin
      side_c.stat = ST_OUTSIDE;
    end else begin
      side_c.stat = ST_MAPPED;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ax_r   <= ax_c;
      s1_ay_r   <= ay_c;
      s1_z_r    <= s0_c_r[2][ZC_W-1:0];
      s1_side_r <= side_c;
    end
  end

  // divider stages
  logic signed [XP_W-1:0] dv_xp, dv_yp;
  dptc_side_t             dv_side;

  dptc_div u_div (
    .clk    (clk),
    .adv    (adv),
    .abs_x  (s1_ax_r),
    .abs_y  (s1_ay_r),
    .zc     (s1_z_r),
    .side_i (s1_side_r),
    .xp     (dv_xp),
    .yp     (dv_yp),
    .side_o (dv_side)
  );

  // squares
  logic signed [59:0] pxx, pyy, pxy;
  logic signed [60:0] psum;
  logic signed [XP_W-1:0] sq_xp_r, sq_yp_r;
  logic signed [31:0]     sq_r2_r, sq_sx_r, sq_sy_r, sq_xy_r;
  dptc_stat_t             sq_st_r;

  assign pxx  = dv_xp * dv_xp;
  assign pyy  = dv_yp * dv_yp;
  assign pxy  = dv_xp * dv_yp;
  assign psum = 61'(pxx) + 61'(pyy);

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_xp_r <= dv_xp;
      sq_yp_r <= dv_yp;
      sq_r2_r <= $signed(psum[59:28]);
      sq_sx_r <= $signed(pxx[59:28]);
      sq_sy_r <= $signed(pyy[59:28]);
      sq_xy_r <= $signed(pxy[59:28]);
      sq_st_r <= dv_side.stat;
    end
  end

  // radial polynomial, step a = k2 + k3*r2
  logic signed [51:0]     ka;
  logic signed [XP_W-1:0] pa_xp_r, pa_yp_r;
  logic signed [31:0]     pa_r2_r, pa_sx_r, pa_sy_r, pa_xy_r;
  logic signed [23:0]     pa_a_r;
  dptc_stat_t             pa_st_r;

  assign ka = k3 * sq_r2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_xp_r <= sq_xp_r;
      pa_yp_r <= sq_yp_r;
      pa_r2_r <= sq_r2_r;
      pa_sx_r <= sq_sx_r;
      pa_sy_r <= sq_sy_r;
      pa_xy_r <= sq_xy_r;
      pa_a_r  <= 24'(k2) + $signed(ka[51:28]);
      pa_st_r <= sq_st_r;
    end
  end

  // step b = k1 + a*r2
  logic signed [55:0]     ab;
  logic signed [XP_W-1:0] pb_xp_r, pb_yp_r;
  logic signed [31:0]     pb_r2_r, pb_sx_r, pb_sy_r, pb_xy_r;
  logic signed [27:0]     pb_b_r;
  dptc_stat_t             pb_st_r;

  assign ab = pa_a_r * pa_r2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pb_xp_r <= pa_xp_r;
      pb_yp_r <= pa_yp_r;
      pb_r2_r <= pa_r2_r;
      pb_sx_r <= pa_sx_r;
      pb_sy_r <= pa_sy_r;
      pb_xy_r <= pa_xy_r;
      pb_b_r  <= 28'(k1) + $signed(ab[55:28]);
      pb_st_r <= pa_st_r;
    end
  end

  // gain g = 1 + b*r2, tangential terms in parallel
  logic signed [59:0]     bg;
  logic signed [33:0]     r2sx, r2sy;
  logic signed [51:0]     p1xy, p2xy;
  logic signed [53:0]     p2rx, p1ry;
  logic signed [35:0]     tx_c, ty_c;
  logic signed [XP_W-1:0] pg_xp_r, pg_yp_r;
  logic signed [31:0]     pg_g_r;
  logic signed [35:0]     pg_tx_r, pg_ty_r;
  dptc_stat_t             pg_st_r;

  assign bg   = pb_b_r * pb_r2_r;
  assign r2sx = 34'(pb_r2_r) + 34'(pb_sx_r <<< 1);
  assign r2sy = 34'(pb_r2_r) + 34'(pb_sy_r <<< 1);
  assign p1xy = p1 * pb_xy_r;
  assign p2xy = p2 * pb_xy_r;
  assign p2rx = p2 * r2sx;
  assign p1ry = p1 * r2sy;
  // the factor of two folds into a shift by one less
  assign tx_c = 36'($signed(p1xy[51:18])) + 36'($signed(p2rx[53:19]));
  assign ty_c = 36'($signed(p1ry[53:19])) + 36'($signed(p2xy[51:18]));

  always_ff @(posedge clk) begin
    if (adv) begin
      pg_xp_r <= pb_xp_r;
      pg_yp_r <= pb_yp_r;
      pg_g_r  <= 32'sd131072 + $signed(bg[59:28]);
      pg_tx_r <= tx_c;
      pg_ty_r <= ty_c;
      pg_st_r <= pb_st_r;
    end
  end

  // distorted normalized coordinates
  logic signed [61:0] xg, yg;
  logic signed [45:0] dn_x_r, dn_y_r;
  dptc_stat_t         dn_st_r;

  assign xg = pg_xp_r * pg_g_r;
  assign yg = pg_yp_r * pg_g_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      dn_x_r  <= 46'($signed(xg[61:17])) + 46'(pg_tx_r);
      dn_y_r  <= 46'($signed(yg[61:17])) + 46'(pg_ty_r);
      dn_st_r <= pg_st_r;
    end
  end

  // projection to pixel coordinates
  logic signed [62:0] fxp, fyp;
  logic signed [63:0] csum, rsum;
  logic signed [31:0] pr_col_r, pr_row_r;
  dptc_stat_t         pr_st_r;

  assign fxp  = $signed({1'b0, fx}) * dn_x_r;
  assign fyp  = $signed({1'b0, fy}) * dn_y_r;
  assign csum = 64'(fxp) + $signed({8'b0, cx, 28'b0});
  assign rsum = 64'(fyp) + $signed({8'b0, cy, 28'b0});

  always_ff @(posedge clk) begin
    if (adv) begin
      pr_col_r <= $signed(csum[63:32]);
      pr_row_r <= $signed(rsum[63:32]);
      pr_st_r  <= dn_st_r;
    end
  end

  // frame check, linear index, output register
  logic              in_frame, mapped;
  logic [IX_W-1:0]   ix;
  logic [COL_W-1:0]  o_col_r;
  logic [ROW_W-1:0]  o_row_r;
  logic [IDX_W-1:0]  o_idx_r;
  dptc_stat_t        o_st_r;

  assign in_frame = pr_col_r >= 0 && pr_col_r < WIDTH_S &&
                    pr_row_r >= 0 && pr_row_r < HEIGHT_S;
  assign mapped   = pr_st_r == ST_MAPPED && in_frame;
  assign ix       = IX_W'(pr_row_r[ROW_B-1:0]) * IX_W'(IMG_WIDTH)
                  + IX_W'(pr_col_r[COL_B-1:0]);

  always_ff @(posedge clk) begin
    if (adv) begin
      o_col_r <= mapped ? pr_col_r[COL_W-1:0] : '0;
      o_row_r <= mapped ? pr_row_r[ROW_W-1:0] : '0;
      o_idx_r <= mapped ? ix[IDX_W-1:0] : '0;
      if (pr_st_r == ST_MAPPED && !in_frame) begin
        o_st_r <= ST_OUTSIDE;
      end else begin
        o_st_r <= pr_st_r;
      end
    end
  end

  assign out_px.valid       = vld_r[NS-1];
  assign out_px.pixel_col   = o_col_r;
  assign out_px.pixel_row   = o_row_r;
  assign out_px.pixel_index = o_idx_r;
  assign out_px.status      = o_st_r;

`ifndef ASSERT_OFF
  a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_px.valid && out_px.status != ST_MAPPED |->
      out_px.pixel_col == '0 && out_px.pixel_row == '0 && out_px.pixel_index == '0)
    else $error("unmapped item carries a nonzero pixel");

  a_mapped_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_px.valid && out_px.status == ST_MAPPED |->
      32'(out_px.pixel_col) < IMG_WIDTH && 32'(out_px.pixel_row) < IMG_HEIGHT)
    else $error("mapped pixel lies outside the frame");

  a_index_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_px.valid && out_px.status == ST_MAPPED |->
      out_px.pixel_index ==
        IDX_W'(IX_W'(out_px.pixel_row) * IX_W'(IMG_WIDTH) + IX_W'(out_px.pixel_col)))
    else $error("linear index disagrees with row and column");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r) && $stable(o_st_r) && $stable(pr_col_r))
    else $error("pipeline moved during a stall");
`endif

endmodule

// File: dv/depth_point_to_color_pixel_core_tb.sv
// ----------------------------------------------------------------------------
// depth_point_to_color_pixel_core_tb
// Drives depth points through the mapper under several camera setups and
// compares every pixel item, in order, against a fixed-point prediction of the
// transform, projection, lens distortion and frame check.
// ----------------------------------------------------------------------------
module depth_point_to_color_pixel_core_tb;
  import dptc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam int PIPE_LAT = 38;
  localparam longint ONE_Q18 = 262144;

  typedef struct {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [IDX_W-1:0] idx;
    dptc_stat_t       st;
  } pixel_t;

  class pixel_scoreboard;
    logic [63:0] regs [7];
    pixel_t      pending_px [$];
    int          errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        CFG_ROT0, CFG_ROT1, CFG_ROT2, CFG_TRANS, CFG_RAD: regs[idx] = data & 64'hFFF_FFFF_FFFF_FFFF;
        CFG_INTR: regs[idx] = data;
        CFG_TAN:  regs[idx] = data & 64'hFF_FFFF_FFFF;
        default: ;
      endcase
    endfunction

    function longint f20(logic [63:0] w, int e);
      logic signed [19:0] t;
      t = 20'(w >> (20 * e));
      return longint'(t);
    endfunction

    function longint xform(int r, longint px, longint py, longint pz);
      return (f20(regs[r], 0) * px + f20(regs[r], 1) * py + f20(regs[r], 2) * pz
              + f20(regs[CFG_TRANS], r) * ONE_Q18) >>> 18;
    endfunction

    function pixel_t map_point(longint px, longint py, longint pz);
      pixel_t res;
      longint xc, yc, zc, xp, yp, r2, a, b, g, xy, sx, sy, xpp, ypp;
      longint k1, k2, k3, p1, p2, fx, fy, cx, cy, col, row;
      res = '{col: '0, row: '0, idx: '0, st: ST_MAPPED};
      if (pz == 0) begin
        res.st = ST_NODEPTH;
        return res;
      end
      xc = xform(0, px, py, pz);
      yc = xform(1, px, py, pz);
      zc = xform(2, px, py, pz);
      if (zc <= 0) begin
        res.st = ST_NODEPTH;
        return res;
      end
      if ((xc < 0 ? -xc : xc) >= 2 * zc || (yc < 0 ? -yc : yc) >= 2 * zc) begin
        res.st = ST_OUTSIDE;
        return res;
      end
      xp = (xc <<< 28) / zc;
      yp = (yc <<< 28) / zc;
      r2 = (xp * xp + yp * yp) >>> 28;
      k1 = f20(regs[CFG_RAD], 0);
      k2 = f20(regs[CFG_RAD], 1);
      k3 = f20(regs[CFG_RAD], 2);
      p1 = f20(regs[CFG_TAN], 0);
      p2 = f20(regs[CFG_TAN], 1);
      a = k2 + ((k3 * r2) >>> 28);
      b = k1 + ((a * r2) >>> 28);
      g = 131072 + ((b * r2) >>> 28);
      xy = (xp * yp) >>> 28;
      sx = (xp * xp) >>> 28;
      sy = (yp * yp) >>> 28;
      xpp = ((xp * g) >>> 17) + ((2 * p1 * xy) >>> 19) + ((p2 * (r2 + 2 * sx)) >>> 19);
      ypp = ((yp * g) >>> 17) + ((p1 * (r2 + 2 * sy)) >>> 19) + ((2 * p2 * xy) >>> 19);
      fx = longint'(regs[CFG_INTR][15:0]);
      fy = longint'(regs[CFG_INTR][31:16]);
      cx = longint'(regs[CFG_INTR][47:32]);
      cy = longint'(regs[CFG_INTR][63:48]);
      col = (fx * xpp + (cx <<< 28)) >>> 32;
      row = (fy * ypp + (cy <<< 28)) >>> 32;
      if (col < 0 || col >= IMG_WIDTH_DEF || row < 0 || row >= IMG_HEIGHT_DEF) begin
        res.st = ST_OUTSIDE;
        return res;
      end
      res.col = col[COL_W-1:0];
      res.row = row[ROW_W-1:0];
      res.idx = IDX_W'(row * IMG_WIDTH_DEF + col);
      return res;
    endfunction

    function void note_point(logic signed [PT_XY_W-1:0] x, logic signed [PT_XY_W-1:0] y,
                             logic [PT_Z_W-1:0] z);
      pending_px.push_back(map_point(longint'(x), longint'(y), longint'(z)));
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_pixel(logic [COL_W-1:0] col, logic [ROW_W-1:0] row, logic [IDX_W-1:0] idx,
                     logic [STAT_W-1:0] st);
      pixel_t e;
      if (pending_px.size() == 0) begin
        report("pixel item with nothing pending");
        return;
      end
      e = pending_px.pop_front();
      if (st !== e.st)
        report($sformatf("status %0d, want %0d", st, e.st));
      if (col !== e.col)
        report($sformatf("pixel_col %0d, want %0d", col, e.col));
      if (row !== e.row)
        report($sformatf("pixel_row %0d, want %0d", row, e.row));
      if (idx !== e.idx)
        report($sformatf("pixel_index %0d, want %0d", idx, e.idx));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  dptc_pt_if pt ();
  dptc_px_if px ();
  pixel_scoreboard sb = new();

  depth_point_to_color_pixel_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pt    (pt.sink),
    .out_px   (px.source),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  initial begin
    rst_n <= 1'b0;
    pt.valid <= 1'b0;
    pt.point_x <= '0;
    pt.point_y <= '0;
    pt.point_z <= '0;
    px.ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_wdata <= '0;
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        px.ready <= 1'b0;
      end else begin
        px.ready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && px.valid && px.ready)
      sb.check_pixel(px.pixel_col, px.pixel_row, px.pixel_index, px.status);
  end

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    sb.set_reg(idx, data);
  endtask

  function automatic logic [63:0] pack3(longint a, longint b, longint c);
    logic [19:0] e0, e1, e2;
    e0 = a[19:0];
    e1 = b[19:0];
    e2 = c[19:0];
    return {4'h0, e2, e1, e0};
  endfunction

  function automatic longint small_val(int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // setups: 1 pinhole identity, 2 near-identity with distortion,
  // 3 all ones, 4 fully random, 5 identity with full-range lens terms, 6 all zeros
  task configure(int setup);
    logic [63:0] v [7];
    case (setup)
      1: begin
        v[0] = pack3(ONE_Q18, 0, 0);
        v[1] = pack3(0, ONE_Q18, 0);
        v[2] = pack3(0, 0, ONE_Q18);
        v[3] = '0;
        v[4] = {16'd3840, 16'd5120, 16'd8000, 16'd8000};
        v[5] = '0;
        v[6] = '0;
      end
      2: begin
        v[0] = pack3(ONE_Q18 + small_val(8000), small_val(8000), small_val(8000));
        v[1] = pack3(small_val(8000), ONE_Q18 + small_val(8000), small_val(8000));
        v[2] = pack3(small_val(8000), small_val(8000), ONE_Q18 + small_val(8000));
        v[3] = pack3(small_val(20000), small_val(20000), small_val(60000));
        v[4] = {16'(3840 + small_val(300)), 16'(5120 + small_val(300)),
                16'(8000 + small_val(800)), 16'(8000 + small_val(800))};
        v[5] = pack3(small_val(40000), small_val(20000), small_val(8000));
        v[6] = {24'h0, 20'(small_val(3000)), 20'(small_val(3000))};
      end
      3: foreach (v[i]) v[i] = '1;
      4: foreach (v[i]) v[i] = {$urandom, $urandom};
      5: begin
        v[0] = pack3(ONE_Q18, 0, 0);
        v[1] = pack3(0, ONE_Q18, 0);
        v[2] = pack3(0, 0, ONE_Q18);
        v[3] = pack3(small_val(4000), small_val(4000), 0);
        v[4] = {$urandom, $urandom};
        v[5] = {$urandom, $urandom} & 64'h0FFF_FFFF_FFFF_FFFF;
        v[6] = {$urandom, $urandom};
      end
      default: foreach (v[i]) v[i] = '0;
    endcase
    write_reg(CFG_ROT0, v[0]);
    write_reg(CFG_ROT1, v[1]);
    write_reg(CFG_ROT2, v[2]);
    write_reg(CFG_TRANS, v[3]);
    write_reg(CFG_INTR, v[4]);
    write_reg(CFG_RAD, v[5]);
    write_reg(CFG_TAN, v[6]);
    write_reg(CFG_SPARE, {$urandom, $urandom});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task send_point(longint x, longint y, longint z);
    logic signed [PT_XY_W-1:0] xs, ys;
    logic [PT_Z_W-1:0] zs;
    xs = x[PT_XY_W-1:0];
    ys = y[PT_XY_W-1:0];
    zs = z[PT_Z_W-1:0];
    if (!calm && $urandom_range(99) < 34) begin
      pt.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    pt.valid <= 1'b1;
    pt.point_x <= xs;
    pt.point_y <= ys;
    pt.point_z <= zs;
    @(posedge clk);
    while (!pt.ready) @(posedge clk);
    sb.note_point(xs, ys, zs);
  endtask

  task send_random_point();
    longint z;
    if ($urandom_range(99) < 80) begin
      z = longint'($urandom_range(1, 524287));
      send_point((longint'($urandom_range(0, 2 * z)) - z) * 7 / 10,
                 (longint'($urandom_range(0, 2 * z)) - z) * 7 / 10, z);
    end else if ($urandom_range(9) == 0) begin
      send_point(small_val(1048575), small_val(1048575), 0);
    end else begin
      send_point(longint'($urandom) - 2147483648, longint'($urandom) - 2147483648,
                 longint'($urandom));
    end
  endtask

  task drain();
    pt.valid <= 1'b0;
    while (sb.pending_px.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
  endtask

  task send_directed();
    longint z;
    z = 65536;
    send_point(0, 0, 0);
    send_point(-1048576, 1048575, 0);
    send_point(0, 0, 524287);
    send_point(0, 0, 1);
    send_point(1048575, 1048575, 524287);
    send_point(-1048576, -1048576, 524287);
    // wide angle right at the limit and just inside it
    send_point(2 * z, 0, z);
    send_point(0, -2 * z, z);
    send_point(2 * z - 1, 0, z);
    // frame edges: col 0 / 639, row 0 / 479 for focal 500 and center (320,240)
    send_point(-z * 320 / 500, 0, z);
    send_point(-z * 320 / 500 - 200, 0, z);
    send_point(z * 319 / 500 + 100, 0, z);
    send_point(z * 320 / 500 + 200, 0, z);
    send_point(0, -z * 240 / 500, z);
    send_point(0, -z * 240 / 500 - 200, z);
    send_point(0, z * 239 / 500 + 100, z);
    send_point(0, z * 240 / 500 + 200, z);
    send_point(z / 3, -z / 4, 3 * z);
  endtask

  initial begin
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: everything lands behind the camera
    for (n = 0; n < 20; n++) send_random_point();
    drain();

    configure(1);
    send_directed();
    for (n = 0; n < 120; n++) send_random_point();
    drain();

    configure(2);
    send_directed();
    hold_req = 1'b1;
    for (n = 0; n < 250; n++) begin
      calm = (n >= 80 && n < 200);
      send_random_point();
    end
    calm = 1'b0;
    drain();

    configure(3);
    for (n = 0; n < 60; n++) send_random_point();
    drain();

    configure(4);
    for (n = 0; n < 80; n++) send_random_point();
    drain();

    configure(5);
    for (n = 0; n < 150; n++) send_random_point();
    drain();

    configure(6);
    for (n = 0; n < 40; n++) send_random_point();
    drain();

    configure(2);
    for (n = 0; n < 120; n++) send_random_point();
    drain();

    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/dptc_pkg.sv
rtl/dptc_pt_if.sv
rtl/dptc_px_if.sv
rtl/dptc_div.sv
rtl/depth_point_to_color_pixel_core.sv
dv/depth_point_to_color_pixel_core_tb.sv
